/* hw/rtl/fcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types and constants of the FAT16 cluster chain reader: command and
// result codes, configuration register indexes and fixed FAT16 values.
// ----------------------------------------------------------------------------
package fcc_pkg;

  // input item commands
  typedef enum logic [1:0] {
    CMD_READ = 2'd0,
    CMD_FAT  = 2'd1,
    CMD_DIR  = 2'd2,
    CMD_ROOT = 2'd3
  } cmd_e;

  // result item kinds
  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_FAT     = 3'd1,
    KIND_END     = 3'd2,
    KIND_MATCH   = 3'd3,
    KIND_NOMATCH = 3'd4,
    KIND_REJECT  = 3'd5
  } kind_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_FAT_START   = 3'd0,
    CFG_ROOT_START  = 3'd1,
    CFG_DATA_START  = 3'd2,
    CFG_SECT_PER_CL = 3'd3,
    CFG_TARGET_NAME = 3'd4,
    CFG_TARGET_EXT  = 3'd5
  } cfg_idx_e;

  localparam logic [15:0] FAT_END_OF_CHAIN = 16'hFFFF;
  localparam int          ATTR_DIR_BIT     = 4;
  localparam logic [7:0]  DOT_CHAR         = 8'h2E;
  localparam logic [31:0] SIZE_UNLIMITED   = 32'hFFFFFFFF;
  localparam logic [7:0]  SPC_RESET        = 8'd1;

endpackage

/* hw/rtl/fat16_cluster_chain_reader.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat16_cluster_chain_reader
// Follows a byte position through a FAT16 cluster chain, turns read requests
// into clamped data reads or FAT lookups, and opens files by 8+3 name.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------
//  in      | in        | in_valid_i / in_stall_o   | cmd, req_bytes, fat_value,
//          |           |                           | entry_* fields
//  out     | out       | out_valid_o / out_stall_i | kind, address, length,
//          |           |                           | exhausted
//  cfg     | in        | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
//  one item per cycle while the output is not stalled; a result reaches the outputs
//  through the input register, then one pass of logic into the result register
//  the single cluster address multiply (cluster times cluster bytes) sets the path
//  a root start item updates the state and gives no result
//  reset clears the valid flags and file state and sets the configuration to its reset values
//  a stall on the output holds the result and backs up into in_stall_o
// ----------------------------------------------------------------------------
module fat16_cluster_chain_reader
  import fcc_pkg::*;
#(
  parameter int SECTOR_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [6:0]  req_bytes_i,
  input  logic [15:0] fat_value_i,
  input  logic [63:0] entry_name_i,
  input  logic [23:0] entry_ext_i,
  input  logic [7:0]  entry_attributes_i,
  input  logic [15:0] entry_cluster_i,
  input  logic [31:0] entry_size_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [31:0] address_o,
  output logic [6:0]  length_o,
  output logic        exhausted_o
);

  localparam int CbW   = 8 + $clog2(SECTOR_BYTES) + 1;
  localparam int ProdW = 16 + CbW;

  // configuration registers
  logic [31:0] fat_start_q, root_start_q, data_base_q;
  logic [7:0]  spc_q;
  logic [63:0] target_name_q;
  logic [23:0] target_ext_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fat_start_q   <= '0;
      root_start_q  <= '0;
      data_base_q   <= '0;
      spc_q         <= SPC_RESET;
      target_name_q <= '0;
      target_ext_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FAT_START:   fat_start_q   <= cfg_wdata_i[31:0];
        CFG_ROOT_START:  root_start_q  <= cfg_wdata_i[31:0];
        CFG_DATA_START:  data_base_q   <= cfg_wdata_i[31:0];
        CFG_SECT_PER_CL: spc_q         <= cfg_wdata_i[7:0];
        CFG_TARGET_NAME: target_name_q <= cfg_wdata_i;
        CFG_TARGET_EXT:  target_ext_q  <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  // input register
  logic        s1_valid_q, s1_valid_d;
  cmd_e        s1_cmd_q;
  logic [6:0]  s1_req_q;
  logic [15:0] s1_fval_q;
  logic [63:0] s1_ename_q;
  logic [23:0] s1_eext_q;
  logic [7:0]  s1_eattr_q;
  logic [15:0] s1_ecl_q;
  logic [31:0] s1_esize_q;

  logic in_take;
  logic fire;
  logic res_valid;

  assign in_take    = in_valid_i && !in_stall_o;
  assign in_stall_o = s1_valid_q && !fire;

  // the stage moves on when the result register is free or no result is made
  assign fire = s1_valid_q && (!res_valid || !out_valid_o || !out_stall_i);

  assign s1_valid_d = in_take || (s1_valid_q && !fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_cmd_q   <= cmd_e'(cmd_i);
      s1_req_q   <= req_bytes_i;
      s1_fval_q  <= fat_value_i;
      s1_ename_q <= entry_name_i;
      s1_eext_q  <= entry_ext_i;
      s1_eattr_q <= entry_attributes_i;
      s1_ecl_q   <= entry_cluster_i;
      s1_esize_q <= entry_size_i;
    end
  end

  // file state
  logic [31:0] pos_q, pos_d;
  logic [15:0] cc_q, cc_d;
  logic [31:0] file_rem_q, file_rem_d;
  logic [31:0] clus_rem_q, clus_rem_d;
  logic [6:0]  pending_q, pending_d;
  logic        awaiting_q, awaiting_d;

  // cluster size and cluster address: data region + cl * cb - 2 * cb
  logic [CbW-1:0]   cb;
  logic [31:0]      cb32;
  logic [15:0]      cl_sel;
  logic [ProdW-1:0] prod;
  logic [31:0]      caddr;

  assign cb     = CbW'(spc_q) * CbW'(SECTOR_BYTES);
  assign cb32   = 32'(cb);
  assign cl_sel = (s1_cmd_q == CMD_FAT) ? s1_fval_q : s1_ecl_q;
  assign prod   = ProdW'(cl_sel) * ProdW'(cb);
  assign caddr  = data_base_q + prod[31:0] - (cb32 << 1);

  // clamped data read, shared by read requests and returned FAT values
  logic [6:0]  rd_want, rd_n1, rd_n;
  logic [31:0] rd_base, rd_file, rd_clus;

  always_comb begin
    if (s1_cmd_q == CMD_FAT) begin
      rd_want = pending_q;
      rd_base = caddr;
      rd_file = file_rem_q;
      rd_clus = cb32;
    end else begin
      rd_want = s1_req_q;
      rd_base = pos_q;
      rd_file = file_rem_q;
      rd_clus = clus_rem_q;
    end
    rd_n1 = (32'(rd_want) > rd_file) ? rd_file[6:0] : rd_want;
    rd_n  = (32'(rd_n1) > rd_clus) ? rd_clus[6:0] : rd_n1;
  end

  // per command state update and result
  kind_e       res_kind;
  logic [31:0] res_addr;
  logic [6:0]  res_len;
  logic        res_exh;
  logic        name_match;
  logic        is_dir;

  assign name_match = (s1_ename_q == target_name_q) && (s1_eext_q == target_ext_q);
  assign is_dir     = (s1_ename_q[63:56] == DOT_CHAR) || s1_eattr_q[ATTR_DIR_BIT];

  always_comb begin
    pos_d      = pos_q;
    cc_d       = cc_q;
    file_rem_d = file_rem_q;
    clus_rem_d = clus_rem_q;
    pending_d  = pending_q;
    awaiting_d = awaiting_q;
    res_valid  = 1'b1;
    res_kind   = KIND_REJECT;
    res_addr   = '0;
    res_len    = '0;
    res_exh    = 1'b0;
    case (s1_cmd_q)
      CMD_READ: begin
        if (awaiting_q) begin
          res_kind = KIND_REJECT;
        end else if (file_rem_q == '0) begin
          res_kind = KIND_END;
        end else if (clus_rem_q == '0) begin
          res_kind   = KIND_FAT;
          res_addr   = fat_start_q + {15'd0, cc_q, 1'b0};
          awaiting_d = 1'b1;
          pending_d  = s1_req_q;
        end else begin
          res_kind   = KIND_DATA;
          res_addr   = rd_base;
          res_len    = rd_n;
          pos_d      = rd_base + 32'(rd_n);
          file_rem_d = rd_file - 32'(rd_n);
          clus_rem_d = rd_clus - 32'(rd_n);
        end
      end
      CMD_FAT: begin
        if (!awaiting_q) begin
          res_kind = KIND_REJECT;
        end else begin
          awaiting_d = 1'b0;
          cc_d       = s1_fval_q;
          clus_rem_d = cb32;
          pending_d  = '0;
          if (s1_fval_q == FAT_END_OF_CHAIN) begin
            file_rem_d = '0;
            res_kind   = KIND_END;
          end else begin
            res_kind   = KIND_DATA;
            res_addr   = rd_base;
            res_len    = rd_n;
            pos_d      = rd_base + 32'(rd_n);
            file_rem_d = rd_file - 32'(rd_n);
            clus_rem_d = rd_clus - 32'(rd_n);
          end
        end
      end
      CMD_DIR: begin
        if (name_match) begin
          cc_d       = s1_ecl_q;
          clus_rem_d = cb32;
          file_rem_d = is_dir ? SIZE_UNLIMITED : s1_esize_q;
          pos_d      = caddr;
          awaiting_d = 1'b0;
          pending_d  = '0;
          res_kind   = KIND_MATCH;
          res_addr   = caddr;
        end else begin
          res_kind = KIND_NOMATCH;
          res_exh  = (file_rem_q == '0);
        end
      end
      CMD_ROOT: begin
        res_valid  = 1'b0;
        pos_d      = root_start_q;
        file_rem_d = data_base_q - root_start_q;
        clus_rem_d = SIZE_UNLIMITED;
        cc_d       = '0;
        pending_d  = '0;
        awaiting_d = 1'b0;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      cc_q       <= '0;
      file_rem_q <= '0;
      clus_rem_q <= '0;
      pending_q  <= '0;
      awaiting_q <= 1'b0;
    end else if (fire) begin
      pos_q      <= pos_d;
      cc_q       <= cc_d;
      file_rem_q <= file_rem_d;
      clus_rem_q <= clus_rem_d;
      pending_q  <= pending_d;
      awaiting_q <= awaiting_d;
    end
  end

  // result register
  logic        out_valid_q, out_valid_d;
  logic        res_load;
  kind_e       kind_q;
  logic [31:0] addr_q;
  logic [6:0]  len_q;
  logic        exh_q;

  assign res_load    = fire && res_valid;
  assign out_valid_d = res_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      kind_q <= res_kind;
      addr_q <= res_addr;
      len_q  <= res_len;
      exh_q  <= res_exh;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign address_o   = addr_q;
  assign length_o    = len_q;
  assign exhausted_o = exh_q;

endmodule

/* hw/rtl/fcc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_checker
// Port level checks on the result channel of the cluster chain reader.
// ----------------------------------------------------------------------------
module fcc_checker
  import fcc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [2:0]  kind_i,
  input logic [31:0] address_i,
  input logic [6:0]  length_i,
  input logic        exhausted_i
);

  // a stalled result item stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(kind_i) &&
      $stable(address_i) && $stable(length_i) && $stable(exhausted_i))
    else $error("result item changed while stalled");

  // only a data read carries a byte count
  a_len_data_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i != KIND_DATA) |-> length_i == '0)
    else $error("nonzero length on a non data result");

  // the exhausted flag only rides on a no match result
  a_exh_nomatch_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && exhausted_i |-> kind_i == KIND_NOMATCH)
    else $error("exhausted set on a result other than no match");

  // results without an address show zero
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == KIND_END || kind_i == KIND_NOMATCH ||
      kind_i == KIND_REJECT) |-> address_i == '0)
    else $error("address on a result that carries none");

endmodule

bind fat16_cluster_chain_reader fcc_checker u_fcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_i      (kind_o),
  .address_i   (address_o),
  .length_i    (length_o),
  .exhausted_i (exhausted_o)
);

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the FAT16 cluster chain reader. An in-bench shadow
// of the chain walker predicts every storage command. Directed tests cover
// reset state, root directory reads, cluster chains, rejections and extreme
// settings. Random phases then open files and follow their chains under random
// settings and, in all but one phase, random input gaps and random output stalls.
// ----------------------------------------------------------------------------
module testbench;
  import fcc_pkg::*;

  localparam int SECTOR_BYTES = 512;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS  = 150;

  typedef struct {
    cmd_e        cmd;
    logic [6:0]  req_bytes;
    logic [15:0] fat_value;
    logic [63:0] entry_name;
    logic [23:0] entry_ext;
    logic [7:0]  entry_attributes;
    logic [15:0] entry_cluster;
    logic [31:0] entry_size;
  } fs_cmd_t;

  typedef struct {
    kind_e       kind;
    logic [31:0] address;
    logic [6:0]  length;
    logic        exhausted;
  } storage_op_t;

  // block ports
  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        cfg_we_i           = 1'b0;
  logic [2:0]  cfg_index_i        = '0;
  logic [63:0] cfg_wdata_i        = '0;
  logic        in_valid_i         = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i              = '0;
  logic [6:0]  req_bytes_i        = '0;
  logic [15:0] fat_value_i        = '0;
  logic [63:0] entry_name_i       = '0;
  logic [23:0] entry_ext_i        = '0;
  logic [7:0]  entry_attributes_i = '0;
  logic [15:0] entry_cluster_i    = '0;
  logic [31:0] entry_size_i       = '0;
  logic        out_valid_o;
  logic        out_stall_i        = 1'b0;
  logic [2:0]  kind_o;
  logic [31:0] address_o;
  logic [6:0]  length_o;
  logic        exhausted_o;

  // shadow settings
  logic [31:0] fat_base  = '0;
  logic [31:0] root_base = '0;
  logic [31:0] data_base = '0;
  logic [7:0]  spc       = SPC_RESET;
  logic [63:0] want_name = '0;
  logic [23:0] want_ext  = '0;

  // shadow walker state
  logic [31:0] pos              = '0;
  logic [15:0] cluster          = '0;
  logic [31:0] bytes_to_eof     = '0;
  logic [31:0] bytes_in_cluster = '0;
  logic [6:0]  held_req         = '0;
  logic        fat_wait         = 1'b0;

  storage_op_t storage_ops_due[$];
  int          errors  = 0;
  bit          gaps_on = 1'b1;

  fat16_cluster_chain_reader #(
    .SECTOR_BYTES(SECTOR_BYTES)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .req_bytes_i       (req_bytes_i),
    .fat_value_i       (fat_value_i),
    .entry_name_i      (entry_name_i),
    .entry_ext_i       (entry_ext_i),
    .entry_attributes_i(entry_attributes_i),
    .entry_cluster_i   (entry_cluster_i),
    .entry_size_i      (entry_size_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_o            (kind_o),
    .address_o         (address_o),
    .length_o          (length_o),
    .exhausted_o       (exhausted_o)
  );

  always #4 clk_i = ~clk_i;

  // random output stalls
  always @(posedge clk_i) begin
    out_stall_i <= gaps_on && ($urandom_range(99) < 8);
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 100) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic storage_op_t mk_op(input kind_e k, input logic [31:0] a,
                                        input logic [6:0] l, input logic x);
    storage_op_t r;
    r.kind      = k;
    r.address   = a;
    r.length    = l;
    r.exhausted = x;
    return r;
  endfunction

  function automatic logic [31:0] cluster_size();
    return {24'd0, spc} * 32'(SECTOR_BYTES);
  endfunction

  function automatic logic [31:0] cluster_base(input logic [15:0] cl);
    return data_base + ({16'd0, cl} - 32'd2) * cluster_size();
  endfunction

  // data read clamped to both remainders
  task automatic clamp_read(input logic [6:0] want);
    logic [31:0] n;
    n = {25'd0, want};
    if (n > bytes_to_eof) n = bytes_to_eof;
    if (n > bytes_in_cluster) n = bytes_in_cluster;
    storage_ops_due.push_back(mk_op(KIND_DATA, pos, n[6:0], 1'b0));
    pos              = pos + n;
    bytes_to_eof     = bytes_to_eof - n;
    bytes_in_cluster = bytes_in_cluster - n;
  endtask

  // advance the shadow walker by one accepted item
  task automatic advance_chain(input fs_cmd_t c);
    logic is_dir;
    case (c.cmd)
      CMD_READ: begin
        if (fat_wait) begin
          storage_ops_due.push_back(mk_op(KIND_REJECT, '0, '0, 1'b0));
        end else if (bytes_to_eof == 0) begin
          storage_ops_due.push_back(mk_op(KIND_END, '0, '0, 1'b0));
        end else if (bytes_in_cluster == 0) begin
          storage_ops_due.push_back(mk_op(KIND_FAT, fat_base + {15'd0, cluster, 1'b0},
                                          '0, 1'b0));
          fat_wait = 1'b1;
          held_req = c.req_bytes;
        end else begin
          clamp_read(c.req_bytes);
        end
      end
      CMD_FAT: begin
        if (!fat_wait) begin
          storage_ops_due.push_back(mk_op(KIND_REJECT, '0, '0, 1'b0));
        end else begin
          fat_wait         = 1'b0;
          cluster          = c.fat_value;
          bytes_in_cluster = cluster_size();
          if (c.fat_value == FAT_END_OF_CHAIN) begin
            bytes_to_eof = '0;
            held_req     = '0;
            storage_ops_due.push_back(mk_op(KIND_END, '0, '0, 1'b0));
          end else begin
            pos = cluster_base(c.fat_value);
            clamp_read(held_req);
            held_req = '0;
          end
        end
      end
      CMD_DIR: begin
        if (c.entry_name == want_name && c.entry_ext == want_ext) begin
          is_dir = (c.entry_name[63:56] == DOT_CHAR) || c.entry_attributes[ATTR_DIR_BIT];
          cluster          = c.entry_cluster;
          bytes_in_cluster = cluster_size();
          bytes_to_eof     = is_dir ? SIZE_UNLIMITED : c.entry_size;
          pos              = cluster_base(c.entry_cluster);
          fat_wait         = 1'b0;
          held_req         = '0;
          storage_ops_due.push_back(mk_op(KIND_MATCH, pos, '0, 1'b0));
        end else begin
          storage_ops_due.push_back(mk_op(KIND_NOMATCH, '0, '0, bytes_to_eof == 0));
        end
      end
      default: begin
        // root start gives no result
        pos              = root_base;
        bytes_to_eof     = data_base - root_base;
        bytes_in_cluster = SIZE_UNLIMITED;
        cluster          = '0;
        held_req         = '0;
        fat_wait         = 1'b0;
      end
    endcase
  endtask

  // compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_storage_ops
    storage_op_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (storage_ops_due.size() == 0) begin
        flag_error($sformatf("result kind %0d with nothing expected", kind_o));
      end else begin
        want = storage_ops_due.pop_front();
        if (kind_o !== want.kind)
          flag_error($sformatf("kind %0d, expected %0d", kind_o, want.kind));
        if (address_o !== want.address)
          flag_error($sformatf("address %h, expected %h", address_o, want.address));
        if (length_o !== want.length)
          flag_error($sformatf("length %0d, expected %0d", length_o, want.length));
        if (exhausted_o !== want.exhausted)
          flag_error($sformatf("exhausted %b, expected %b", exhausted_o, want.exhausted));
      end
    end
  end

  // send one item, with a random gap before it
  task automatic send_cmd(input fs_cmd_t c);
    while (gaps_on && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    cmd_i              <= c.cmd;
    req_bytes_i        <= c.req_bytes;
    fat_value_i        <= c.fat_value;
    entry_name_i       <= c.entry_name;
    entry_ext_i        <= c.entry_ext;
    entry_attributes_i <= c.entry_attributes;
    entry_cluster_i    <= c.entry_cluster;
    entry_size_i       <= c.entry_size;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_chain(c);
  endtask

  // stop sending and wait for every predicted result
  task automatic wait_idle(input int extra);
    in_valid_i <= 1'b0;
    while (storage_ops_due.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // item of one command with every other field random
  function automatic fs_cmd_t any_cmd(input cmd_e c);
    fs_cmd_t r;
    r.cmd              = c;
    r.req_bytes        = 7'($urandom);
    r.fat_value        = 16'($urandom);
    r.entry_name       = {$urandom, $urandom};
    r.entry_ext        = 24'($urandom);
    r.entry_attributes = 8'($urandom);
    r.entry_cluster    = 16'($urandom);
    r.entry_size       = $urandom;
    return r;
  endfunction

  task automatic read_bytes(input logic [6:0] n);
    fs_cmd_t c;
    c = any_cmd(CMD_READ);
    c.req_bytes = n;
    send_cmd(c);
  endtask

  task automatic give_fat(input logic [15:0] v);
    fs_cmd_t c;
    c = any_cmd(CMD_FAT);
    c.fat_value = v;
    send_cmd(c);
  endtask

  task automatic offer_entry(input logic [63:0] name, input logic [23:0] ext,
                             input logic [7:0] attr, input logic [15:0] cl,
                             input logic [31:0] size);
    fs_cmd_t c;
    c = any_cmd(CMD_DIR);
    c.entry_name       = name;
    c.entry_ext        = ext;
    c.entry_attributes = attr;
    c.entry_cluster    = cl;
    c.entry_size       = size;
    send_cmd(c);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_FAT_START:   fat_base  = value[31:0];
      CFG_ROOT_START:  root_base = value[31:0];
      CFG_DATA_START:  data_base = value[31:0];
      CFG_SECT_PER_CL: spc       = value[7:0];
      CFG_TARGET_NAME: want_name = value;
      default:         want_ext  = value[23:0];
    endcase
  endtask

  // write all registers; unused upper data bits carry noise
  task automatic load_config(input logic [31:0] fat, input logic [31:0] root,
                             input logic [31:0] data, input logic [7:0] sectors,
                             input logic [63:0] name, input logic [23:0] ext);
    write_reg(CFG_FAT_START, {$urandom, fat});
    write_reg(CFG_ROOT_START, {$urandom, root});
    write_reg(CFG_DATA_START, {$urandom, data});
    write_reg(CFG_SECT_PER_CL, {$urandom, 24'($urandom), sectors});
    write_reg(CFG_TARGET_NAME, name);
    write_reg(CFG_TARGET_EXT, {$urandom, 8'($urandom), ext});
    cfg_we_i <= 1'b0;
  endtask

  // settings and state straight after reset
  task automatic test_reset_state();
    read_bytes(7'd127);
    give_fat(16'h1234);
    offer_entry(64'd0, 24'd0, 8'h00, 16'd2, 32'd5);
    read_bytes(7'd127);
    read_bytes(7'd1);
    offer_entry("NOTTHERE", "BIN", 8'h00, 16'd7, 32'd9);
    wait_idle(DRAIN_CYCLES);
  endtask

  // root directory: unlimited cluster, size from the region gap
  task automatic test_root_directory();
    load_config(32'h0000_4000, 32'h0001_0000, 32'h0001_0100, 8'd1, "README  ", "TXT");
    send_cmd(any_cmd(CMD_ROOT));
    read_bytes(7'd0);
    read_bytes(7'd127);
    read_bytes(7'd127);
    read_bytes(7'd127);
    read_bytes(7'd127);
    wait_idle(DRAIN_CYCLES);
  endtask

  // chain walk, lookups, rejections and end of chain
  task automatic test_cluster_chain();
    offer_entry("README  ", "TXT", 8'h20, 16'd3, 32'd700);
    repeat (4) read_bytes(7'd127);
    read_bytes(7'd127);
    read_bytes(7'd100);
    read_bytes(7'd5);
    offer_entry("README  ", "TXZ", 8'h20, 16'd3, 32'd700);
    give_fat(16'd5);
    read_bytes(7'd127);
    read_bytes(7'd127);
    // cluster one wraps below the data region
    offer_entry("README  ", "TXT", 8'h00, 16'd1, 32'd600);
    repeat (5) read_bytes(7'd127);
    give_fat(FAT_END_OF_CHAIN);
    read_bytes(7'd3);
    give_fat(16'd9);
    // directory matches at cluster zero and with the directory attribute
    offer_entry("README  ", "TXT", 8'h00, 16'd0, 32'd600);
    repeat (5) read_bytes(7'd127);
    offer_entry("README  ", "TXT", 8'(1 << ATTR_DIR_BIT), 16'd4, 32'd0);
    read_bytes(7'd127);
    wait_idle(DRAIN_CYCLES);
  endtask

  // extreme settings: zero and 128 sector clusters, wrapping addresses
  task automatic test_extreme_settings();
    load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 8'd0,
                {DOT_CHAR, 56'hFF_FFFF_FFFF_FFFF}, 24'hFF_FFFF);
    offer_entry({DOT_CHAR, 56'hFF_FFFF_FFFF_FFFF}, 24'hFF_FFFF, 8'h00, 16'hFFFF, 32'd0);
    read_bytes(7'd127);
    give_fat(16'd2);
    read_bytes(7'd64);
    give_fat(FAT_END_OF_CHAIN);
    send_cmd(any_cmd(CMD_ROOT));
    read_bytes(7'd10);
    wait_idle(DRAIN_CYCLES);
    load_config(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 8'd128,
                64'hFFFF_FFFF_FFFF_FFFF, 24'h00_0000);
    send_cmd(any_cmd(CMD_ROOT));
    read_bytes(7'd127);
    offer_entry(64'hFFFF_FFFF_FFFF_FFFF, 24'h00_0000, 8'hEF, 16'hFFFE, 32'hFFFF_FFFF);
    read_bytes(7'd127);
    offer_entry(64'hFFFF_FFFF_FFFF_FFFE, 24'h00_0000, 8'hFF, 16'hFFFE, 32'hFFFF_FFFF);
    wait_idle(DRAIN_CYCLES);
  endtask

  // random settings, well-formed file walks with noise mixed in
  task automatic test_random_walks();
    int          roll;
    logic [7:0]  sectors;
    logic [63:0] name;
    logic [23:0] ext;
    logic [7:0]  attr;
    logic [31:0] size;
    for (int phase = 0; phase < 6; phase++) begin
      roll = $urandom_range(9);
      if (roll < 6) sectors = 8'($urandom_range(1, 4));
      else if (roll == 6) sectors = 8'd0;
      else if (roll == 7) sectors = 8'd128;
      else sectors = 8'($urandom);
      name = {$urandom, $urandom};
      if ($urandom_range(3) == 0) name[63:56] = DOT_CHAR;
      load_config($urandom, $urandom, $urandom, sectors, name, 24'($urandom));
      gaps_on = (phase != 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        roll = $urandom_range(99);
        if (roll < 12) begin
          send_cmd(any_cmd(cmd_e'(2'($urandom))));
        end else if (fat_wait) begin
          give_fat(roll < 20 ? FAT_END_OF_CHAIN : 16'($urandom));
        end else if (roll < 15) begin
          send_cmd(any_cmd(CMD_ROOT));
        end else if (bytes_to_eof == 0 || roll < 20) begin
          attr = 8'($urandom);
          if ($urandom_range(3) != 0) attr[ATTR_DIR_BIT] = 1'b0;
          size = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 4000);
          name = want_name;
          ext  = want_ext;
          // near miss on one bit of the name or extension
          if ($urandom_range(6) == 0) begin
            if ($urandom_range(1)) name[$urandom_range(63)] ^= 1'b1;
            else ext[$urandom_range(23)] ^= 1'b1;
          end
          offer_entry(name, ext, attr, 16'($urandom), size);
        end else begin
          read_bytes(7'($urandom));
        end
        // sender holds off until everything is back
        if ($urandom_range(199) == 0) wait_idle(1);
      end
      wait_idle(DRAIN_CYCLES);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_root_directory();
    test_cluster_chain();
    test_extreme_settings();
    test_random_walks();
    wait_idle(8);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", storage_ops_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/fcc_pkg.sv
hw/rtl/fat16_cluster_chain_reader.sv
hw/rtl/fcc_checker.sv
dv/testbench.sv
